>>> sv/xtea_pkg.sv
`timescale 1ns / 1ps

package xtea_pkg;

  localparam int WORD_W      = 32;
  localparam int KEY_WORDS   = 4;
  localparam int CFG_INDEX_W = 3;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [KEY_WORDS-1:0] key_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam word_t DELTA = 32'h9e37_79b9;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  typedef struct packed {
    logic  action;
    word_t half_a;
    word_t half_b;
  } blk_t;

  function automatic word_t xtea_mix(word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

>>> sv/xtea_in_if.sv
`timescale 1ns / 1ps

interface xtea_in_if;
  import xtea_pkg::*;

  logic  valid;
  logic  ready;
  logic  action;
  word_t half_a_in;
  word_t half_b_in;

  modport source (output valid, output action, output half_a_in, output half_b_in,
                  input ready);
  modport sink (input valid, input action, input half_a_in, input half_b_in,
                output ready);
endinterface

>>> sv/xtea_out_if.sv
`timescale 1ns / 1ps

interface xtea_out_if;
  import xtea_pkg::*;

  logic  valid;
  logic  ready;
  word_t half_a_out;
  word_t half_b_out;

  modport source (output valid, output half_a_out, output half_b_out, input ready);
  modport sink (input valid, input half_a_out, input half_b_out, output ready);
endinterface

>>> sv/xtea_half_round.sv
`timescale 1ns / 1ps

module xtea_half_round #(
  parameter bit          SECOND  = 1'b0,
  parameter logic [31:0] SUM_ENC = 32'h0,
  parameter logic [31:0] SUM_DEC = 32'h0
) (
  input  logic          clk,
  input  logic          rst,
  input  xtea_pkg::key_t  keys,
  input  logic          up_valid,
  input  xtea_pkg::blk_t  up_blk,
  output logic          up_ready,
  output logic          down_valid,
  output xtea_pkg::blk_t  down_blk,
  input  logic          down_ready
);
  import xtea_pkg::*;

  localparam logic [1:0] KIDX_ENC = SECOND ? SUM_ENC[12:11] : SUM_ENC[1:0];
  localparam logic [1:0] KIDX_DEC = SECOND ? SUM_DEC[1:0] : SUM_DEC[12:11];

  logic  enc;
  logic  upd_a;
  word_t src;
  word_t tgt;
  word_t round_key;
  word_t f_val;
  word_t tgt_next;
  blk_t  blk_next;

  assign enc      = (up_blk.action == OP_ENCRYPT);
  assign upd_a    = enc ^ SECOND;
  assign src      = upd_a ? up_blk.half_b : up_blk.half_a;
  assign tgt      = upd_a ? up_blk.half_a : up_blk.half_b;
  assign round_key = enc ? (SUM_ENC + keys[KIDX_ENC]) : (SUM_DEC + keys[KIDX_DEC]);
  assign f_val    = xtea_mix(src) ^ round_key;
  assign tgt_next = enc ? (tgt + f_val) : (tgt - f_val);

  always_comb begin
    blk_next = up_blk;
    if (upd_a) begin
      blk_next.half_a = tgt_next;
    end else begin
      blk_next.half_b = tgt_next;
    end
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_blk <= blk_next;
    end
  end
endmodule

>>> sv/xtea_block_cipher.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output is not stalled; one register stage per Feistel half-round.
// Each stage holds its item while the next stage is not ready, so bubbles collapse on a stall.
// Reset (rst, synchronous, active high) clears the stage valid bits and the key words.
module xtea_block_cipher #(
  parameter int CYCLES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  xtea_in_if.sink               blk_in,
  xtea_out_if.source            blk_out,
  input  logic                  cfg_write,
  input  xtea_pkg::cfg_index_t  cfg_index,
  input  xtea_pkg::word_t       cfg_data
);
  import xtea_pkg::*;

  localparam int DEPTH = 2 * CYCLES;

  key_t keys;
  logic valid [DEPTH+1];
  logic rdy   [DEPTH+1];
  blk_t blk   [DEPTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (cfg_write && (cfg_index < CFG_INDEX_W'(KEY_WORDS))) begin
      keys[cfg_index[1:0]] <= cfg_data;
    end
  end

  assign valid[0]       = blk_in.valid;
  assign blk[0].action  = blk_in.action;
  assign blk[0].half_a  = blk_in.half_a_in;
  assign blk[0].half_b  = blk_in.half_b_in;
  assign blk_in.ready   = rdy[0];

  for (genvar c = 0; c < CYCLES; c++) begin : g_cycle
    localparam logic [31:0] SE0 = 32'(DELTA * 32'(c));
    localparam logic [31:0] SE1 = 32'(DELTA * 32'(c + 1));
    localparam logic [31:0] SD0 = 32'(DELTA * 32'(CYCLES - c));
    localparam logic [31:0] SD1 = 32'(DELTA * 32'(CYCLES - c - 1));

    xtea_half_round #(
      .SECOND  (1'b0),
      .SUM_ENC (SE0),
      .SUM_DEC (SD0)
    ) u_first (
      .clk        (clk),
      .rst        (rst),
      .keys       (keys),
      .up_valid   (valid[2*c]),
      .up_blk     (blk[2*c]),
      .up_ready   (rdy[2*c]),
      .down_valid (valid[2*c+1]),
      .down_blk   (blk[2*c+1]),
      .down_ready (rdy[2*c+1])
    );

    xtea_half_round #(
      .SECOND  (1'b1),
      .SUM_ENC (SE1),
      .SUM_DEC (SD1)
    ) u_second (
      .clk        (clk),
      .rst        (rst),
      .keys       (keys),
      .up_valid   (valid[2*c+1]),
      .up_blk     (blk[2*c+1]),
      .up_ready   (rdy[2*c+1]),
      .down_valid (valid[2*c+2]),
      .down_blk   (blk[2*c+2]),
      .down_ready (rdy[2*c+2])
    );
  end

  assign rdy[DEPTH]         = blk_out.ready;
  assign blk_out.valid      = valid[DEPTH];
  assign blk_out.half_a_out = blk[DEPTH].half_a;
  assign blk_out.half_b_out = blk[DEPTH].half_b;
endmodule

>>> sv/xtea_checker.sv
`timescale 1ns / 1ps

module xtea_checker #(
  parameter int CYCLES = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] half_a_out,
  input logic [31:0] half_b_out
);
  localparam int DEPTH = 2 * CYCLES;
  localparam int CNT_W = $clog2(DEPTH + 1) + 1;

  logic [CNT_W-1:0] outstanding;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding <= outstanding + 1'b1;
    end else if (out_acc && !in_acc) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  a_out_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(half_a_out) && $stable(half_b_out))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != '0)
    else $error("result without an item in flight");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= CNT_W'(DEPTH))
    else $error("more items in flight than stages");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    outstanding == '0 |-> in_ready)
    else $error("empty pipeline refuses an item");
endmodule

bind xtea_block_cipher xtea_checker #(
  .CYCLES (CYCLES)
) u_xtea_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (blk_in.valid),
  .in_ready   (blk_in.ready),
  .out_valid  (blk_out.valid),
  .out_ready  (blk_out.ready),
  .half_a_out (blk_out.half_a_out),
  .half_b_out (blk_out.half_b_out)
);

>>> test/xtea_block_cipher_test.sv
`timescale 1ns / 1ps

module xtea_block_cipher_test;
  import xtea_pkg::*;

  localparam int ROUND_CYCLES = 32;
  localparam int LATENCY = 2 * ROUND_CYCLES;
  localparam int CYCLE_LIMIT = 400000;

  localparam cfg_index_t KEY_WORD_0_IDX = 3'd0;
  localparam cfg_index_t KEY_WORD_1_IDX = 3'd1;
  localparam cfg_index_t KEY_WORD_2_IDX = 3'd2;
  localparam cfg_index_t KEY_WORD_3_IDX = 3'd3;

  typedef struct {
    word_t half_a;
    word_t half_b;
  } block_t;

  logic clk;
  logic rst;
  logic cfg_write;
  cfg_index_t cfg_index;
  word_t cfg_data;

  xtea_in_if in_ch();
  xtea_out_if out_ch();

  xtea_block_cipher #(.CYCLES(ROUND_CYCLES)) DUT (
    .clk(clk),
    .rst(rst),
    .blk_in(in_ch),
    .blk_out(out_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  word_t key_model [KEY_WORDS];
  block_t pending_blocks[$];
  int mismatches;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t feistel_f(word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic block_t xtea_predict(op_t op, word_t a, word_t b);
    word_t v0;
    word_t v1;
    word_t sum;
    block_t res;
    v0 = a;
    v1 = b;
    if (op == OP_ENCRYPT) begin
      sum = '0;
      for (int c = 0; c < ROUND_CYCLES; c++) begin
        v0 = v0 + (feistel_f(v1) ^ (sum + key_model[sum[1:0]]));
        sum = sum + DELTA;
        v1 = v1 + (feistel_f(v0) ^ (sum + key_model[sum[12:11]]));
      end
    end else begin
      sum = word_t'(DELTA * ROUND_CYCLES);
      for (int c = 0; c < ROUND_CYCLES; c++) begin
        v1 = v1 - (feistel_f(v0) ^ (sum + key_model[sum[12:11]]));
        sum = sum - DELTA;
        v0 = v0 - (feistel_f(v1) ^ (sum + key_model[sum[1:0]]));
      end
    end
    res.half_a = v0;
    res.half_b = v1;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Check results against the oldest prediction, then record newly accepted items.
  always @(posedge clk) begin
    block_t exp_blk;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_blocks.size() == 0) begin
          report_mismatch($sformatf("unexpected result %08h %08h",
                                    out_ch.half_a_out, out_ch.half_b_out));
        end else begin
          exp_blk = pending_blocks.pop_front();
          if (out_ch.half_a_out !== exp_blk.half_a)
            report_mismatch($sformatf("half_a_out %08h, expected %08h",
                                      out_ch.half_a_out, exp_blk.half_a));
          if (out_ch.half_b_out !== exp_blk.half_b)
            report_mismatch($sformatf("half_b_out %08h, expected %08h",
                                      out_ch.half_b_out, exp_blk.half_b));
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_blocks.push_back(xtea_predict(op_t'(in_ch.action), in_ch.half_a_in,
                                              in_ch.half_b_in));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_block(op_t op, word_t a, word_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = op;
    in_ch.half_a_in = a;
    in_ch.half_b_in = b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_key(cfg_index_t idx, word_t data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx < KEY_WORDS) key_model[idx[1:0]] = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Encrypt a block, then decrypt the predicted ciphertext.
  task automatic send_round_trip(word_t a, word_t b);
    block_t ct;
    ct = xtea_predict(OP_ENCRYPT, a, b);
    send_block(OP_ENCRYPT, a, b);
    send_block(OP_DECRYPT, ct.half_a, ct.half_b);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_zero_key();
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '1, '1);
    send_block(OP_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555);
    send_block(OP_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa);
    wait_idle();
  endtask

  task automatic test_key_extremes();
    for (int i = 0; i < KEY_WORDS; i++) write_key(cfg_index_t'(KEY_WORD_0_IDX + i), '1);
    send_round_trip('0, '1);
    send_round_trip('1, '0);
    wait_idle();
    write_key(KEY_WORD_0_IDX, 32'h0001_0203);
    write_key(KEY_WORD_1_IDX, 32'h0405_0607);
    write_key(KEY_WORD_2_IDX, 32'h0809_0a0b);
    write_key(KEY_WORD_3_IDX, 32'h0c0d_0e0f);
    send_round_trip(32'h4142_4344, 32'h4546_4748);
    send_block(OP_DECRYPT, 32'h8000_0000, 32'h0000_0001);
    wait_idle();
  endtask

  task automatic test_ignored_index();
    for (int i = KEY_WORDS; i < 2 ** CFG_INDEX_W; i++)
      write_key(cfg_index_t'(i), $urandom);
    send_round_trip(32'h0123_4567, 32'h89ab_cdef);
    wait_idle();
  endtask

  task automatic test_key_change();
    for (int i = 0; i < KEY_WORDS; i++) begin
      write_key(cfg_index_t'(KEY_WORD_0_IDX + i), $urandom);
      send_block(OP_ENCRYPT, 32'hdead_beef, 32'h1234_5678);
      wait_idle();
    end
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    int sent;
    int kind;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < KEY_WORDS; i++)
      write_key(cfg_index_t'(KEY_WORD_0_IDX + i), pick_word());
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        send_round_trip($urandom, $urandom);
        sent += 2;
      end else if (kind < 90) begin
        send_block(op_t'($urandom_range(1)), $urandom, $urandom);
        sent++;
      end else begin
        send_block(op_t'($urandom_range(1)), pick_word(), pick_word());
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = KEY_WORD_0_IDX;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = OP_ENCRYPT;
    in_ch.half_a_in = '0;
    in_ch.half_b_in = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < KEY_WORDS; i++) key_model[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_zero_key();
    test_key_extremes();
    test_ignored_index();
    test_key_change();
    test_random(200, 20, 51);
    test_random(200, 51, 20);
    test_random(200, 0, 0);

    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> xtea_block_cipher.f
sv/xtea_pkg.sv
sv/xtea_in_if.sv
sv/xtea_out_if.sv
sv/xtea_half_round.sv
sv/xtea_block_cipher.sv
sv/xtea_checker.sv
test/xtea_block_cipher_test.sv
